// ===== sv/pcdc_pkg.sv =====
// ---------------------------------------------------------------------------
// pcdc_pkg
// Shared types and codes for the pointer click/drag classifier: payload
// structs, button phase encoding, event and status codes.
// ---------------------------------------------------------------------------
package pcdc_pkg;

    localparam int CODE_W       = 29;
    localparam int POS_W        = 16;
    localparam int STAMP_W      = 32;
    localparam int THRESH_W     = 8;
    localparam int THRESH_SQ_W  = 2 * THRESH_W;
    localparam int BUTTONS_DEF  = 5;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd15;

    // Input event kinds
    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_MOTION  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_EVENT    = 2'd0;
    localparam logic [1:0] ST_CONSUMED = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;

    // Produced event kinds
    localparam logic [2:0] EV_KEY         = 3'd0;
    localparam logic [2:0] EV_CLICK       = 3'd1;
    localparam logic [2:0] EV_DRAG_START  = 3'd2;
    localparam logic [2:0] EV_DRAG_UPDATE = 3'd3;
    localparam logic [2:0] EV_DRAG_END    = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_DRAGGING = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [CODE_W-1:0]      code;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [STAMP_W-1:0]     stamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [2:0]             event_kind;
        logic [CODE_W-1:0]      out_code;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic [STAMP_W-1:0]     out_stamp;
        logic                   click_count;
    } out_item_t;

endpackage

// ===== sv/pcdc_far_check.sv =====
// ---------------------------------------------------------------------------
// pcdc_far_check
// Squared-distance test between two points against a squared threshold.
// Full precision: 17-bit differences, 33-bit sum of squares.
// ---------------------------------------------------------------------------
module pcdc_far_check
    import pcdc_pkg::*;
(
    input  logic signed [POS_W-1:0]  ax,
    input  logic signed [POS_W-1:0]  ay,
    input  logic signed [POS_W-1:0]  bx,
    input  logic signed [POS_W-1:0]  by,
    input  logic [THRESH_SQ_W-1:0]   thresh_sq,
    output logic                     far
);

    logic signed [POS_W:0]     dx;
    logic signed [POS_W:0]     dy;
    logic signed [2*POS_W+1:0] dx_sq;
    logic signed [2*POS_W+1:0] dy_sq;
    logic [2*POS_W:0]          dist_sq;

    // Form differences and their squares
    assign dx    = {ax[POS_W-1], ax} - {bx[POS_W-1], bx};
    assign dy    = {ay[POS_W-1], ay} - {by[POS_W-1], by};
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    // Sum and compare; each square fits in 32 bits
    assign dist_sq = {1'b0, dx_sq[2*POS_W-1:0]} + {1'b0, dy_sq[2*POS_W-1:0]};
    assign far     = dist_sq > {{(2*POS_W+1-THRESH_SQ_W){1'b0}}, thresh_sq};

endmodule

// ===== sv/pcdc_tracker.sv =====
// ---------------------------------------------------------------------------
// pcdc_tracker
// Per-button phase and anchor state plus the classification logic.
// Result is combinational from the current item; state updates on step.
// ---------------------------------------------------------------------------
module pcdc_tracker
    import pcdc_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  in_item_t               item,
    input  logic [THRESH_SQ_W-1:0] thresh_sq,
    output out_item_t              result
);

    localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    phase_t                  phase_reg    [BUTTONS];
    logic signed [POS_W-1:0] anchor_x_reg [BUTTONS];
    logic signed [POS_W-1:0] anchor_y_reg [BUTTONS];

    logic                    drag_found;
    logic                    press_found;
    logic [IDX_W-1:0]        drag_idx;
    logic [IDX_W-1:0]        press_idx;
    logic                    btn_ok;
    logic [CODE_W-1:0]       code_m1;
    logic [IDX_W-1:0]        btn_idx;
    logic [IDX_W-1:0]        sel_idx;
    logic signed [POS_W-1:0] anc_x;
    logic signed [POS_W-1:0] anc_y;
    phase_t                  btn_phase;
    logic                    far;

    logic                    phase_wr;
    phase_t                  phase_val;
    logic                    anchor_wr;

    // Find highest dragging and highest pressed buttons
    always_comb
    begin
        drag_found  = 1'b0;
        press_found = 1'b0;
        drag_idx    = '0;
        press_idx   = '0;
        for (int i = 0; i < BUTTONS; i++)
        begin
            if (phase_reg[i] == PH_DRAGGING)
            begin
                drag_found = 1'b1;
                drag_idx   = IDX_W'(i);
            end
            if (phase_reg[i] == PH_PRESSED)
            begin
                press_found = 1'b1;
                press_idx   = IDX_W'(i);
            end
        end
    end

    // Decode button number; out-of-range maps to entry zero and is never used
    assign btn_ok  = (item.code != '0) && (item.code <= CODE_W'(BUTTONS));
    assign code_m1 = item.code - CODE_W'(1);
    assign btn_idx = btn_ok ? code_m1[IDX_W-1:0] : '0;

    // Select the one button whose anchor matters for this item
    assign sel_idx   = (item.kind == KIND_MOTION) ? (drag_found ? drag_idx : press_idx)
                                                  : btn_idx;
    assign anc_x     = anchor_x_reg[sel_idx];
    assign anc_y     = anchor_y_reg[sel_idx];
    assign btn_phase = phase_reg[btn_idx];

    pcdc_far_check u_far (
        .ax        (anc_x),
        .ay        (anc_y),
        .bx        (item.pos_x),
        .by        (item.pos_y),
        .thresh_sq (thresh_sq),
        .far       (far)
    );

    // Classify the item and decide the state update
    always_comb
    begin
        result    = '0;
        phase_wr  = 1'b0;
        phase_val = PH_IDLE;
        anchor_wr = 1'b0;
        case (item.kind)
            KIND_KEY:
            begin
                result.status      = ST_EVENT;
                result.event_kind  = EV_KEY;
                result.out_code    = item.code;
                result.end_x       = item.pos_x;
                result.end_y       = item.pos_y;
                result.out_stamp   = item.stamp;
                result.click_count = 1'b1;
            end
            KIND_MOTION:
            begin
                if (drag_found)
                begin
                    result.status     = ST_EVENT;
                    result.event_kind = EV_DRAG_UPDATE;
                    result.out_code   = CODE_W'(drag_idx) + CODE_W'(1);
                    result.end_x      = item.pos_x;
                    result.end_y      = item.pos_y;
                    result.origin_x   = anc_x;
                    result.origin_y   = anc_y;
                    result.out_stamp  = item.stamp;
                end
                else if (!press_found)
                begin
                    result.status = ST_IGNORED;
                end
                else if (!far)
                begin
                    result.status = ST_CONSUMED;
                end
                else
                begin
                    phase_wr          = 1'b1;
                    phase_val         = PH_DRAGGING;
                    result.status     = ST_EVENT;
                    result.event_kind = EV_DRAG_START;
                    result.out_code   = CODE_W'(press_idx) + CODE_W'(1);
                    result.end_x      = item.pos_x;
                    result.end_y      = item.pos_y;
                    result.origin_x   = anc_x;
                    result.origin_y   = anc_y;
                    result.out_stamp  = item.stamp;
                end
            end
            KIND_PRESS:
            begin
                if (!btn_ok)
                begin
                    result.status = ST_IGNORED;
                end
                else
                begin
                    result.status = ST_CONSUMED;
                    if (btn_phase == PH_IDLE)
                    begin
                        phase_wr  = 1'b1;
                        phase_val = PH_PRESSED;
                        anchor_wr = 1'b1;
                    end
                end
            end
            KIND_RELEASE:
            begin
                if (!btn_ok)
                begin
                    result.status = ST_IGNORED;
                end
                else
                begin
                    phase_wr  = 1'b1;
                    phase_val = PH_IDLE;
                    case (btn_phase)
                        PH_PRESSED:
                        begin
                            if (far)
                            begin
                                result.status = ST_CONSUMED;
                            end
                            else
                            begin
                                result.status      = ST_EVENT;
                                result.event_kind  = EV_CLICK;
                                result.out_code    = item.code;
                                result.end_x       = item.pos_x;
                                result.end_y       = item.pos_y;
                                result.out_stamp   = item.stamp;
                                result.click_count = 1'b1;
                            end
                        end
                        PH_DRAGGING:
                        begin
                            result.status      = ST_EVENT;
                            result.event_kind  = EV_DRAG_END;
                            result.out_code    = item.code;
                            result.end_x       = item.pos_x;
                            result.end_y       = item.pos_y;
                            result.origin_x    = anc_x;
                            result.origin_y    = anc_y;
                            result.out_stamp   = item.stamp;
                            result.click_count = 1'b1;
                        end
                        default:
                        begin
                            result.status = ST_CONSUMED;
                        end
                    endcase
                end
            end
            default:
            begin
                result.status = ST_IGNORED;
            end
        endcase
    end

    // Advance button phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTONS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
            end
        end
        else if (step && phase_wr)
        begin
            phase_reg[sel_idx] <= phase_val;
        end
    end

    // Capture the anchor on a press from idle
    always_ff @(posedge clk)
    begin
        if (step && anchor_wr)
        begin
            anchor_x_reg[btn_idx] <= item.pos_x;
            anchor_y_reg[btn_idx] <= item.pos_y;
        end
    end

endmodule

// ===== sv/pointer_click_drag_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// pointer_click_drag_classifier_unit
// Input register, then result register: an item taken at the input waits in the
// input register, and out_valid rises when it moves on into the result register.
// Throughput: one item per cycle while out_stall does not hold the result register,
// set by the single classify-and-distance pass between the two registers.
// Reset: all buttons idle, threshold 15, both stages empty; anchors are
// loaded by presses and carry no reset.
// ---------------------------------------------------------------------------
module pointer_click_drag_classifier_unit
    import pcdc_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr,
    input  logic [THRESH_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data
);

    logic [THRESH_SQ_W-1:0] thresh_sq_reg;
    logic [THRESH_SQ_W-1:0] thresh_sq_next;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    in_item_t               s1_item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_item_t              out_item_reg;
    out_item_t              result;
    logic                   advance;
    logic                   in_take;

    // Hold the threshold squared so the distance pass needs no extra multiply
    assign thresh_sq_next = THRESH_SQ_W'(cfg_data) * THRESH_SQ_W'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_sq_reg <= THRESH_SQ_W'(THRESH_RESET) * THRESH_SQ_W'(THRESH_RESET);
        end
        else if (cfg_wr)
        begin
            thresh_sq_reg <= thresh_sq_next;
        end
    end

    // Transfer control: advance when the result register is free or draining
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load input and result payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    pcdc_tracker #(
        .BUTTONS (BUTTONS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (s1_item_reg),
        .thresh_sq (thresh_sq_reg),
        .result    (result)
    );

endmodule
